// ===== sv/sama_pkg.sv =====
// shared types and constants for the sampled converter moving average
`timescale 1ns / 1ps

package sama_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int VALUE_W     = 16;
   localparam int INTERVAL_W  = 10;
   localparam int AVG_LEN_W   = 7;
   localparam int VREF_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = VREF_W + VALUE_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;

   localparam logic [VALUE_W-1:0] VALUE_MAX    = 16'hFFFF;
   localparam logic [VALUE_W-1:0] FAILED_VALUE = 16'hFFFF;
   localparam logic [11:0]        FULL_SCALE   = 12'd4095;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd100;
   localparam logic [AVG_LEN_W-1:0]  AVG_LEN_RESET  = 7'd16;
   localparam logic [VREF_W-1:0]     VREF_RESET     = 16'd3300;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VREF_MV         = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                read_failed;
   } req_type;

   typedef struct packed {
      logic               sampled;
      logic [VALUE_W-1:0] last_sample;
      logic [VALUE_W-1:0] mean;
      logic [VALUE_W-1:0] mean_mv;
   } rsp_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic               take;
      logic [VALUE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic [AVG_LEN_W-1:0] avg_len;
      logic [VREF_W-1:0]    vref;
      logic                 clear;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_MULT,
      ST_REDUCE,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

// ===== sv/sama_front.sv =====
// front end: tick counting and sample classification
`timescale 1ns / 1ps

module sama_front import sama_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic [INTERVAL_W-1:0] interval,
   input  logic                  queue_full,
   output logic                  push_valid,
   output item_type              push_item
);

   logic [INTERVAL_W-1:0] elapsed_ff;
   logic [INTERVAL_W-1:0] elapsed_in;
   logic                  accept;
   logic                  take;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign take       = elapsed_ff >= interval;
   assign push_valid = accept;

   always_comb begin
      push_item.take  = take;
      push_item.value = req_data.read_failed ? FAILED_VALUE
                                             : VALUE_W'(req_data.sample);
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      if (accept) begin
         elapsed_in = take ? '0 : elapsed_ff + INTERVAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== sv/sama_queue.sv =====
// two-entry queue between front and back
`timescale 1ns / 1ps

module sama_queue import sama_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   output logic     empty,
   input  logic     pop,
   output item_type head
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = count_ff == QCOUNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/sama_back.sv =====
// back end: sample ring, running sum, serial mean divider and millivolt scaling
`timescale 1ns / 1ps

module sama_back import sama_pkg::*; #(
   parameter int MAX_AVERAGE_LENGTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     queue_empty,
   input  item_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int IDX_W = (MAX_AVERAGE_LENGTH > 1) ? $clog2(MAX_AVERAGE_LENGTH) : 1;
   localparam int LEN_W = $clog2(MAX_AVERAGE_LENGTH + 1);
   localparam int SUM_W = VALUE_W + $clog2(MAX_AVERAGE_LENGTH);
   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam int REM_W = LEN_W + 1;
   localparam int S1_W  = PROD_W - 11;
   localparam int Q1_W  = PROD_W - 12;
   localparam int HI_W  = S1_W - 12;
   localparam int S2_W  = 13;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   store_ff [MAX_AVERAGE_LENGTH];
   logic [VALUE_W-1:0]   rd_data_ff;
   logic                 take_ff, take_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]     widx_ff, widx_in;
   logic                 wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [VALUE_W-1:0]   latest_ff, latest_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   mean_ff, mean_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [S1_W-1:0]      s1_ff, s1_in;
   logic [Q1_W-1:0]      q1_ff, q1_in;
   logic [VALUE_W-1:0]   mv_ff, mv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]     len;
   logic                 out_free;
   logic                 do_update, do_divide, do_mult, do_reduce, do_finish, do_load;
   logic                 div_last;
   logic [VALUE_W-1:0]   old_value;
   logic [SUM_W-1:0]     sum_upd;
   logic [LEN_W-1:0]     widx_inc;
   logic                 wrap;
   logic [REM_W-1:0]     trial;
   logic                 trial_ge;
   logic [VALUE_W-1:0]   mean_sat;
   logic [HI_W-1:0]      s1_hi;
   logic [S2_W-1:0]      s2;
   logic [S1_W-1:0]      q_full;

   // length zero counts as one, above the store depth as the depth
   always_comb begin
      if (cfg.avg_len == '0) begin
         len = LEN_W'(1);
      end else if (int'(cfg.avg_len) > MAX_AVERAGE_LENGTH) begin
         len = LEN_W'(MAX_AVERAGE_LENGTH);
      end else begin
         len = LEN_W'(cfg.avg_len);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_last = cnt_ff == CNT_W'(SUM_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (!queue_empty) state_in = ST_READ;
         ST_READ:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_last) state_in = ST_MULT;
         ST_MULT:   state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      pop       = 1'b0;
      do_update = 1'b0;
      do_divide = 1'b0;
      do_mult   = 1'b0;
      do_reduce = 1'b0;
      do_finish = 1'b0;
      do_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   pop = !queue_empty;
         ST_READ:   do_update = 1'b1;
         ST_DIVIDE: do_divide = 1'b1;
         ST_MULT:   do_mult = 1'b1;
         ST_REDUCE: do_reduce = 1'b1;
         ST_FINISH: do_finish = 1'b1;
         ST_DONE:   do_load = out_free;
         default:   pop = 1'b0;
      endcase
   end

   // entries at or past the write index are unwritten until the ring wraps
   assign old_value = wrapped_ff ? rd_data_ff : '0;
   assign sum_upd   = sum_ff - SUM_W'(old_value) + SUM_W'(value_ff);
   assign widx_inc  = LEN_W'(widx_ff) + LEN_W'(1);
   assign wrap      = widx_inc >= len;

   assign trial    = {rem_ff[REM_W-2:0], quo_ff[SUM_W-1]};
   assign trial_ge = trial >= {1'b0, len};
   assign mean_sat = (quo_ff > SUM_W'(VALUE_MAX)) ? VALUE_MAX : quo_ff[VALUE_W-1:0];

   // x / 4095 with x = 4096a + b: fold a + b twice, then one correction
   assign s1_hi  = s1_ff[S1_W-1:12];
   assign s2     = S2_W'(s1_hi) + S2_W'(s1_ff[11:0]);
   assign q_full = S1_W'(q1_ff) + S1_W'(s1_hi) + S1_W'(s2 >= S2_W'(FULL_SCALE));

   always_comb begin
      take_in      = take_ff;
      value_in     = value_ff;
      widx_in      = widx_ff;
      wrapped_in   = wrapped_ff;
      sum_in       = sum_ff;
      latest_in    = latest_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      s1_in        = s1_ff;
      q1_in        = q1_ff;
      mv_in        = mv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (pop) begin
         take_in  = head.take;
         value_in = head.value;
      end
      if (do_update) begin
         rem_in = '0;
         cnt_in = '0;
         quo_in = sum_ff;
         if (take_ff) begin
            sum_in    = sum_upd;
            quo_in    = sum_upd;
            latest_in = value_ff;
            widx_in   = wrap ? '0 : IDX_W'(widx_inc);
            if (wrap) begin
               wrapped_in = 1'b1;
            end
         end
      end
      if (do_divide) begin
         rem_in = trial_ge ? trial - {1'b0, len} : trial;
         quo_in = {quo_ff[SUM_W-2:0], trial_ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (do_mult) begin
         mean_in = mean_sat;
         prod_in = PROD_W'(cfg.vref) * PROD_W'(mean_sat);
      end
      if (do_reduce) begin
         s1_in = S1_W'(prod_ff[PROD_W-1:12]) + S1_W'(prod_ff[11:0]);
         q1_in = prod_ff[PROD_W-1:12];
      end
      if (do_finish) begin
         mv_in = (q_full > S1_W'(VALUE_MAX)) ? VALUE_MAX : q_full[VALUE_W-1:0];
      end
      if (do_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.sampled     = take_ff;
         rsp_data_in.last_sample = latest_ff;
         rsp_data_in.mean        = mean_ff;
         rsp_data_in.mean_mv     = mv_ff;
      end
      // a length write restarts the ring
      if (cfg.clear) begin
         widx_in    = '0;
         wrapped_in = 1'b0;
         sum_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         widx_ff      <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      take_ff     <= take_in;
      value_ff    <= value_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      s1_ff       <= s1_in;
      q1_ff       <= q1_in;
      mv_ff       <= mv_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (do_update && take_ff) begin
         store_ff[widx_ff] <= value_ff;
      end
      rd_data_ff <= store_ff[widx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   ast_idx_in_ring: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(widx_ff) < len)
      else $error("write index outside the ring length");

   ast_empty_ring_sum: assert property (@(posedge clock) disable iff (reset)
      (!wrapped_ff && widx_ff == '0) |-> sum_ff == '0)
      else $error("running sum nonzero with an empty ring");

   ast_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

// ===== sv/sampled_adc_moving_average.sv =====
// path: a taken tick beat passes the queue, then the back-end states read, divide, multiply,
// reduce, finish and done, and the result register loads once the receiver is not stalling
// the back end takes no new tick until it is through with the last, paced by the bit-serial mean divider
// two ticks queue ahead of the back end, so input is taken while a result waits
// reset: synchronous, active high; registers to defaults and the ring empties at once
// top level: configuration registers and front, queue and back instances
`timescale 1ns / 1ps

module sampled_adc_moving_average import sama_pkg::*; #(
   parameter int MAX_AVERAGE_LENGTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [AVG_LEN_W-1:0]  avg_len_ff, avg_len_in;
   logic [VREF_W-1:0]     vref_ff, vref_in;
   logic                  csr_write;
   cfg_type               cfg;
   logic                  push_valid;
   item_type              push_item;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  pop;
   item_type              head;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      interval_in = interval_ff;
      avg_len_in  = avg_len_ff;
      vref_in     = vref_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_in = csr_data[INTERVAL_W-1:0];
            CSR_AVERAGE_LENGTH:  avg_len_in  = csr_data[AVG_LEN_W-1:0];
            CSR_VREF_MV:         vref_in     = csr_data[VREF_W-1:0];
            default:             interval_in = interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         avg_len_ff  <= AVG_LEN_RESET;
         vref_ff     <= VREF_RESET;
      end else begin
         interval_ff <= interval_in;
         avg_len_ff  <= avg_len_in;
         vref_ff     <= vref_in;
      end
   end

   always_comb begin
      cfg.avg_len = avg_len_ff;
      cfg.vref    = vref_ff;
      cfg.clear   = csr_write && (csr_index == CSR_AVERAGE_LENGTH);
   end

   sama_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .interval   (interval_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   sama_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop        (pop),
      .head       (head)
   );

   sama_back #(
      .MAX_AVERAGE_LENGTH (MAX_AVERAGE_LENGTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
// testbench for the sampled converter moving average: directed rows, then random phases
`timescale 1ns / 1ps

module testbench;
   import sama_pkg::*;

   localparam int MAX_LEN     = 64;
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]    csr_val;
      req_type                  tick;
      logic                     typed;
      rsp_type                  want;
   } row_type;

   typedef struct packed {
      logic    given;
      rsp_type value;
   } override_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state
   logic [INTERVAL_W-1:0] cfg_interval;
   logic [AVG_LEN_W-1:0]  cfg_length;
   logic [VREF_W-1:0]     cfg_vref;
   logic [VALUE_W-1:0]    ring [MAX_LEN];
   int unsigned           ring_pos;
   int unsigned           ring_sum;
   logic [INTERVAL_W-1:0] ticks_since;
   logic [VALUE_W-1:0]    held_value;

   rsp_type      pending_rsp [$];
   override_type fixed_rsp [$];
   int           errors = 0;
   int           cycle_count = 0;
   int           stall_pct = 0;
   int           stall_quiet = 0;

   row_type plan [34] = '{
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'd0, 1'b0}, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
      '{ROW_CSR, CSR_SAMPLE_INTERVAL, 16'd0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_AVERAGE_LENGTH, 16'd1, '0, 1'b0, '0},
      '{ROW_CSR, CSR_VREF_MV, 16'd4095, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b0}, 1'b1,
        '{1'b1, 16'd4095, 16'd4095, 16'd4095}},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hAAA, 1'b1}, 1'b1,
        '{1'b1, 16'd65535, 16'd65535, 16'd65535}},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h555, 1'b0}, 1'b1,
        '{1'b1, 16'd1365, 16'd1365, 16'd1365}},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h000, 1'b0}, 1'b1, '{1'b1, 16'd0, 16'd0, 16'd0}},
      '{ROW_CSR, CSR_VREF_MV, 16'd65535, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b0}, 1'b1,
        '{1'b1, 16'd4095, 16'd4095, 16'd65535}},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hAAA, 1'b0}, 1'b1,
        '{1'b1, 16'd2730, 16'd2730, 16'd43690}},
      // millivolt result saturates
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h555, 1'b1}, 1'b1,
        '{1'b1, 16'd65535, 16'd65535, 16'd65535}},
      '{ROW_CSR, CSR_VREF_MV, 16'd0, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b0}, 1'b1,
        '{1'b1, 16'd4095, 16'd4095, 16'd0}},
      // length zero acts as one
      '{ROW_CSR, CSR_AVERAGE_LENGTH, 16'd0, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h800, 1'b0}, 1'b1,
        '{1'b1, 16'd2048, 16'd2048, 16'd0}},
      // oversized length clamps to the store depth
      '{ROW_CSR, CSR_VREF_MV, 16'd3300, '0, 1'b0, '0},
      '{ROW_CSR, CSR_AVERAGE_LENGTH, 16'd127, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h000, 1'b1}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h555, 1'b0}, 1'b0, '0},
      '{ROW_CSR, CSR_AVERAGE_LENGTH, 16'd64, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b1}, 1'b0, '0},
      '{ROW_CSR, CSR_SAMPLE_INTERVAL, 16'd3, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h123, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h456, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h789, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hABC, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hDEF, 1'b0}, 1'b0, '0},
      // write to an unused index must change nothing
      '{ROW_CSR, CSR_SPARE, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h321, 1'b0}, 1'b0, '0},
      // upper data bits are dropped, leaving 1000
      '{ROW_CSR, CSR_SAMPLE_INTERVAL, 16'hFFE8, '0, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'h654, 1'b0}, 1'b0, '0},
      '{ROW_TICK, CSR_SPARE, 16'd0, '{12'hFFF, 1'b1}, 1'b0, '0}
   };

   sampled_adc_moving_average #(
      .MAX_AVERAGE_LENGTH(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type filter_tick(req_type t);
      int unsigned       len;
      int unsigned       slot;
      int unsigned       avg;
      logic [VALUE_W-1:0] v;
      longint unsigned   mv;
      rsp_type           r;
      len = cfg_length;
      if (len < 1) len = 1;
      if (len > MAX_LEN) len = MAX_LEN;
      r.sampled = 1'b0;
      if (ticks_since >= cfg_interval) begin
         v = t.read_failed ? FAILED_VALUE : {4'd0, t.sample};
         slot = (ring_pos >= len) ? 0 : ring_pos;
         ring_sum = ring_sum - ring[slot] + v;
         ring[slot] = v;
         slot++;
         ring_pos = (slot >= len) ? 0 : slot;
         held_value = v;
         ticks_since = '0;
         r.sampled = 1'b1;
      end else begin
         ticks_since = ticks_since + 1'b1;
      end
      avg = ring_sum / len;
      if (avg > 65535) avg = 65535;
      mv = (longint'(cfg_vref) * longint'(avg)) / FULL_SCALE;
      if (mv > 65535) mv = 65535;
      r.last_sample = held_value;
      r.mean        = avg[VALUE_W-1:0];
      r.mean_mv     = mv[VALUE_W-1:0];
      return r;
   endfunction

   task automatic compare_rsp(rsp_type want, rsp_type got);
      if (got.sampled !== want.sampled) begin
         $error("sampled: expected %0d, actual %0d", want.sampled, got.sampled);
         errors++;
      end
      if (got.last_sample !== want.last_sample) begin
         $error("last_sample: expected %0d, actual %0d", want.last_sample, got.last_sample);
         errors++;
      end
      if (got.mean !== want.mean) begin
         $error("mean: expected %0d, actual %0d", want.mean, got.mean);
         errors++;
      end
      if (got.mean_mv !== want.mean_mv) begin
         $error("mean_mv: expected %0d, actual %0d", want.mean_mv, got.mean_mv);
         errors++;
      end
   endtask

   // bookkeeping at the rising edge: register writes, tick beats, result beats
   always @(posedge clock) begin : watch
      rsp_type      predicted;
      override_type fixed;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_INTERVAL: cfg_interval = csr_data[INTERVAL_W-1:0];
               CSR_AVERAGE_LENGTH: begin
                  cfg_length = csr_data[AVG_LEN_W-1:0];
                  for (int k = 0; k < MAX_LEN; k++) ring[k] = '0;
                  ring_pos = 0;
                  ring_sum = 0;
               end
               CSR_VREF_MV: cfg_vref = csr_data[VREF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = filter_tick(req_data);
            if (fixed_rsp.size() != 0) begin
               fixed = fixed_rsp.pop_front();
               if (fixed.given) predicted = fixed.value;
            end
            pending_rsp.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               errors++;
            end else begin
               compare_rsp(pending_rsp.pop_front(), rsp_data);
            end
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver back-pressure, with stall-free stretches now and then
   always @(negedge clock) begin
      if (stall_quiet > 0) begin
         stall_quiet--;
         rsp_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 49) == 0) begin
         stall_quiet = $urandom_range(10, 30);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // entered and left at a falling edge; leaves req_valid high after the beat
   task automatic send_tick(req_type t, int gap_pct);
      while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] interval, logic [CSR_DATA_W-1:0] length,
                            logic [CSR_DATA_W-1:0] vref, int count, int gap_pct,
                            int stall_level, int drain_at);
      req_type t;
      int      quiet;
      quiet = 0;
      settle();
      write_reg(CSR_SAMPLE_INTERVAL, interval);
      write_reg(CSR_AVERAGE_LENGTH, length);
      write_reg(CSR_VREF_MV, vref);
      csr_valid <= 1'b0;
      stall_pct = stall_level;
      for (int n = 0; n < count; n++) begin
         // sender holds off until the block has delivered everything
         if (n == drain_at) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 7) == 0)
            t.sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         else
            t.sample = 12'($urandom_range(0, 4095));
         t.read_failed = ($urandom_range(0, 7) == 0);
         if (quiet > 0) begin
            quiet--;
            send_tick(t, 0);
         end else begin
            if (gap_pct > 0 && $urandom_range(0, 49) == 0) quiet = $urandom_range(10, 30);
            send_tick(t, gap_pct);
         end
      end
   endtask

   initial begin
      cfg_interval = INTERVAL_RESET;
      cfg_length   = AVG_LEN_RESET;
      cfg_vref     = VREF_RESET;
      for (int k = 0; k < MAX_LEN; k++) ring[k] = '0;
      ring_pos    = 0;
      ring_sum    = 0;
      ticks_since = '0;
      held_value  = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < $size(plan); i++) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR) settle();
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            if (i > 0 && plan[i-1].kind == ROW_CSR) csr_valid <= 1'b0;
            fixed_rsp.push_back('{plan[i].typed, plan[i].want});
            send_tick(plan[i].tick, 0);
         end
      end

      run_phase(16'd0, 16'd64, 16'hFFFF, 200, 0, 0, -1);
      run_phase(16'd0, 16'd1, 16'd0, 150, 47, 0, -1);
      run_phase(16'd2, 16'd7, 16'd3300, 180, 0, 47, 90);
      run_phase(16'($urandom_range(0, 4)), 16'($urandom_range(1, 64)),
                16'($urandom_range(0, 65535)), 200, 26, 26, -1);
      run_phase(16'hFC00 | 16'd1000, 16'd16, 16'd3300, 150, 0, 0, -1);
      run_phase(16'd3, 16'hFF80, 16'($urandom_range(0, 65535)), 150, 47, 0, -1);
      run_phase(16'd1, 16'hFF7F, 16'($urandom_range(0, 65535)), 200, 0, 47, -1);
      run_phase({6'($urandom_range(0, 63)), 10'($urandom_range(0, 6))},
                {9'($urandom_range(0, 511)), 7'($urandom_range(0, 127))},
                16'($urandom_range(0, 65535)), 200, 26, 26, -1);

      settle();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
